### hw/rtl/edtp_pkg.sv
// edtp_pkg: types and constants shared by the earliest-deadline task picker
// no dependencies; compiled first
`default_nettype none

package edtp_pkg;

    localparam int TASK_MAX     = 8;
    localparam int TASK_COUNT_D = 8;
    localparam int TASK_IDX_W   = 3;
    localparam int MASK_W       = 8;
    localparam int TIME_W       = 40;
    localparam int PERIOD_W     = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000;

    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [PERIOD_W-1:0] period_t;

    // result of one pass through the shared add/compare unit
    typedef struct packed {
        time_t deadline;
        logic  take;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/edtp_req_if.sv
// edtp_req_if: request channel carrying the live-task mask
// depends on edtp_pkg
`default_nettype none

interface edtp_req_if;
    import edtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] alive_mask;

    modport source (output valid, output alive_mask, input ready);
    modport sink (input valid, input alive_mask, output ready);

endinterface

`default_nettype wire

### hw/rtl/edtp_rsp_if.sv
// edtp_rsp_if: result channel carrying the chosen task and its deadline
// depends on edtp_pkg
`default_nettype none

interface edtp_rsp_if;
    import edtp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TASK_IDX_W-1:0] chosen_task;
    logic                  none_alive;
    logic [TIME_W-1:0]     chosen_deadline;

    modport source (output valid, output chosen_task, output none_alive,
                    output chosen_deadline, input ready);
    modport sink (input valid, input chosen_task, input none_alive,
                  input chosen_deadline, output ready);

endinterface

`default_nettype wire

### hw/rtl/edtp_cfg_regs.sv
// edtp_cfg_regs: per-task period registers with a write port and one read port
// depends on edtp_pkg
`default_nettype none

module edtp_cfg_regs #(
    parameter int TASK_COUNT = edtp_pkg::TASK_COUNT_D,
    parameter int TASK_W     = $clog2(TASK_COUNT)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [edtp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [edtp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [TASK_W-1:0]               rd_idx,
    output edtp_pkg::period_t                    rd_period
);
    import edtp_pkg::*;

    period_t period_reg [TASK_COUNT];
    logic    hit;

    // writes to indexes past the task count are dropped
    assign hit = cfg_we && ({1'b0, cfg_idx} < (CFG_IDX_W + 1)'(TASK_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                period_reg[i] <= PERIOD_RESET;
            end
        end
        else if (hit)
        begin
            period_reg[cfg_idx[TASK_W-1:0]] <= cfg_data[PERIOD_W-1:0];
        end
    end

    assign rd_period = period_reg[rd_idx];

endmodule

`default_nettype wire

### hw/rtl/edtp_cmp_unit.sv
// edtp_cmp_unit: shared deadline adder and comparator, used once per scan step
// depends on edtp_pkg
`default_nettype none

module edtp_cmp_unit (
    input  wire edtp_pkg::time_t   release_t,
    input  wire edtp_pkg::period_t period,
    input  wire edtp_pkg::time_t   best_d,
    input  wire logic              found,
    input  wire logic              is_last,
    output edtp_pkg::cmp_res_t     res
);
    import edtp_pkg::*;

    time_t d;

    // wraps modulo 2^40
    assign d = release_t + TIME_W'(period);

    assign res.deadline = d;
    // previous winner keeps a tie, otherwise the earlier index stays
    assign res.take = !found || (d < best_d) || ((d == best_d) && is_last);

endmodule

`default_nettype wire

### hw/rtl/earliest_deadline_task_picker_top.sv
// earliest_deadline_task_picker_top: sequencer, release-time table, result register
// depends on edtp_pkg, edtp_req_if, edtp_rsp_if, edtp_cfg_regs, edtp_cmp_unit
//
// usage: a request item carries alive_mask, one bit per task. the block scans
// tasks 0 .. TASK_COUNT-1, one per cycle through a single 40-bit adder and
// comparator, and picks the live task with the smallest release+period
// deadline (the previous winner keeps ties, then the lowest index). the
// result item gives that task and its deadline; the task's release time then
// moves up by one period. with no live task, none_alive is set, chosen_task
// repeats the previous choice, the deadline reads zero and no state changes.
// after a request is accepted the block scans every task, then loads the result
// register in the write state. req.ready is high only while idle, so a new
// request waits until the previous result is loaded. if the receiver stalls,
// the result waits in the output register and the next finished scan holds until
// it is taken. reset clears all release times to zero, the last choice to task 0
// and the periods to 1000. the user must write periods only while idle, through
// cfg_we/cfg_idx/cfg_data; the block itself does not enforce this.
`default_nettype none

module earliest_deadline_task_picker_top #(
    parameter int TASK_COUNT = edtp_pkg::TASK_COUNT_D
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    edtp_req_if.sink                             req,
    edtp_rsp_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [edtp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [edtp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import edtp_pkg::*;

    localparam int TASK_W = $clog2(TASK_COUNT);

    state_t              state_reg, state_next;
    logic [TASK_W-1:0]   idx_reg;
    logic [TASK_COUNT-1:0] mask_reg;
    logic                found_reg;
    time_t               best_d_reg;
    logic [TASK_W-1:0]   best_t_reg;
    logic [TASK_W-1:0]   last_reg;
    time_t               rel_reg [TASK_COUNT];

    logic                out_valid_reg;
    logic [TASK_IDX_W-1:0] out_task_reg;
    logic                out_none_reg;
    time_t               out_d_reg;

    period_t             period;
    cmp_res_t            cmp;
    logic                accept;
    logic                step_take;
    logic                scan_end;
    logic                out_free;
    logic                commit;

    edtp_cfg_regs #(
        .TASK_COUNT (TASK_COUNT),
        .TASK_W     (TASK_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .rd_idx    (idx_reg),
        .rd_period (period)
    );

    edtp_cmp_unit u_cmp (
        .release_t (rel_reg[idx_reg]),
        .period    (period),
        .best_d    (best_d_reg),
        .found     (found_reg),
        .is_last   (idx_reg == last_reg),
        .res       (cmp)
    );

    assign scan_end  = (idx_reg == TASK_W'(TASK_COUNT - 1));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign step_take = (state_reg == ST_SCAN) && mask_reg[idx_reg] && cmp.take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_SCAN:  commit = 1'b0;
            ST_WRITE: commit = out_free;
            default:  req.ready = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                rel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && !scan_end)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (step_take)
            begin
                found_reg <= 1'b1;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (found_reg)
                begin
                    rel_reg[best_t_reg] <= best_d_reg;
                    last_reg            <= best_t_reg;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= req.alive_mask[TASK_COUNT-1:0];
        end
        if (step_take)
        begin
            best_d_reg <= cmp.deadline;
            best_t_reg <= idx_reg;
        end
        if (commit)
        begin
            if (found_reg)
            begin
                out_task_reg <= TASK_IDX_W'(best_t_reg);
                out_none_reg <= 1'b0;
                out_d_reg    <= best_d_reg;
            end
            else
            begin
                out_task_reg <= TASK_IDX_W'(last_reg);
                out_none_reg <= 1'b1;
                out_d_reg    <= '0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.chosen_task     = out_task_reg;
    assign rsp.none_alive      = out_none_reg;
    assign rsp.chosen_deadline = out_d_reg;

endmodule

`default_nettype wire
